[src/q2e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants and the arctangent table of the converter
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int QW        = 16;   // quaternion component width
  localparam int OPW       = 34;   // atan2 operand width
  localparam int SW        = 30;   // clamped asin argument width
  localparam int VW        = 57;   // radicand width
  localparam int CW        = 29;   // square root width
  localparam int XW        = 38;   // cordic vector width
  localparam int AW        = 35;   // cordic angle width
  localparam int SQ_STAGES = 29;   // one root bit per stage
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN = 24;

  localparam logic signed [OPW-1:0] ONE_Q28 = OPW'(64'sd268435456);
  localparam logic signed [AW-1:0]  PI_Q30  = AW'(64'sd3373259426);
  localparam logic signed [18:0]    FULL_LIMIT = 19'sd25736;
  localparam logic signed [18:0]    HALF_LIMIT = 19'sd12868;

  typedef struct packed {
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [SW-1:0]  sin_p;
    logic                  clamped;
  } ops_t;

  // atan(2^-i) at scale 2^30, truncated
  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/q2e_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_front
// products, sums, asin clamp, and the radicand 1 - s*s (four stages)
// ----------------------------------------------------------------------------
module q2e_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              vld_in,
  input  wire  signed [q2e_pkg::QW-1:0]    w,
  input  wire  signed [q2e_pkg::QW-1:0]    x,
  input  wire  signed [q2e_pkg::QW-1:0]    y,
  input  wire  signed [q2e_pkg::QW-1:0]    z,
  output logic                             vld_out,
  output logic        [q2e_pkg::VW-1:0]    rad_out,
  output q2e_pkg::ops_t                    ops_out
);

  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  logic v1_r, v2_r, v3_r, v4_r;
  q2e_pkg::ops_t ops2_r, ops3_r, ops4_r, ops2_nxt;
  logic [q2e_pkg::VW-1:0] sq3_r, rad4_r;
  logic signed [32:0] sum_rl, sum_rr, sum_yl, sum_yr, diff_s;
  logic signed [33:0] s_full;
  logic signed [59:0] sq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    sum_rl = 33'(p_wx_r) + 33'(p_yz_r);
    sum_rr = 33'(p_xx_r) + 33'(p_yy_r);
    sum_yl = 33'(p_wz_r) + 33'(p_xy_r);
    sum_yr = 33'(p_yy_r) + 33'(p_zz_r);
    diff_s = 33'(p_wy_r) - 33'(p_zx_r);
    s_full = {diff_s, 1'b0};
    ops2_nxt.roll_y = {sum_rl, 1'b0};
    ops2_nxt.roll_x = q2e_pkg::ONE_Q28 - $signed({sum_rr, 1'b0});
    ops2_nxt.yaw_y  = {sum_yl, 1'b0};
    ops2_nxt.yaw_x  = q2e_pkg::ONE_Q28 - $signed({sum_yr, 1'b0});
    if (s_full > q2e_pkg::ONE_Q28) begin
      ops2_nxt.sin_p   = q2e_pkg::SW'(q2e_pkg::ONE_Q28);
      ops2_nxt.clamped = 1'b1;
    end else if (s_full < -q2e_pkg::ONE_Q28) begin
      ops2_nxt.sin_p   = q2e_pkg::SW'(-q2e_pkg::ONE_Q28);
      ops2_nxt.clamped = 1'b1;
    end else begin
      ops2_nxt.sin_p   = q2e_pkg::SW'(s_full);
      ops2_nxt.clamped = 1'b0;
    end
    sq_full = ops2_r.sin_p * ops2_r.sin_p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= w * x;
      p_yz_r <= y * z;
      p_xx_r <= x * x;
      p_yy_r <= y * y;
      p_wz_r <= w * z;
      p_xy_r <= x * y;
      p_zz_r <= z * z;
      p_wy_r <= w * y;
      p_zx_r <= z * x;
      ops2_r <= ops2_nxt;
      ops3_r <= ops2_r;
      sq3_r  <= sq_full[q2e_pkg::VW-1:0];
      ops4_r <= ops3_r;
      rad4_r <= (q2e_pkg::VW'(1) << 56) - sq3_r;
    end
  end

  assign vld_out = v4_r;
  assign rad_out = rad4_r;
  assign ops_out = ops4_r;

endmodule
`default_nettype wire

[src/q2e_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_isqrt
// pipelined integer square root, one result bit per stage, with side payload
// ----------------------------------------------------------------------------
module q2e_isqrt #(
  parameter int PW = 1
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           vld_in,
  input  wire  [q2e_pkg::VW-1:0]        rad_in,
  input  wire  [PW-1:0]                 pay_in,
  output logic                          vld_out,
  output logic [q2e_pkg::CW-1:0]        root_out,
  output logic [PW-1:0]                 pay_out
);

  localparam int NS = q2e_pkg::SQ_STAGES;
  localparam int RW = q2e_pkg::VW + 1;

  logic [RW-1:0] rem_r [NS];
  logic [RW-1:0] res_r [NS];
  logic [PW-1:0] pay_r [NS];
  logic [NS-1:0] vld_r;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic [RW-1:0] rem_i, res_i, trial, rem_nxt, res_nxt;
      logic [RW-1:0] bitv;
      assign bitv = RW'(1) << (2 * (NS - 1 - k));
      if (k == 0) begin : g_first
        assign rem_i = RW'(rad_in);
        assign res_i = '0;
      end else begin : g_rest
        assign rem_i = rem_r[k-1];
        assign res_i = res_r[k-1];
      end
      always_comb begin
        trial = res_i + bitv;
        if (rem_i >= trial) begin
          rem_nxt = rem_i - trial;
          res_nxt = (res_i >> 1) + bitv;
        end else begin
          rem_nxt = rem_i;
          res_nxt = res_i >> 1;
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= (k == 0) ? vld_in : vld_r[(k == 0) ? 0 : k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          res_r[k] <= res_nxt;
          pay_r[k] <= (k == 0) ? pay_in : pay_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  assign vld_out  = vld_r[NS-1];
  assign root_out = res_r[NS-1][q2e_pkg::CW-1:0];
  assign pay_out  = pay_r[NS-1];

endmodule
`default_nettype wire

[src/q2e_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2, one micro-rotation per stage
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                clk,
  input  wire                                en,
  input  wire  signed [q2e_pkg::OPW-1:0]     y_in,
  input  wire  signed [q2e_pkg::OPW-1:0]     x_in,
  output logic signed [q2e_pkg::AW-1:0]      ang_out,
  output logic                               zero_out
);

  localparam int XW = q2e_pkg::XW;
  localparam int AW = q2e_pkg::AW;

  logic signed [XW-1:0] x_r [STAGES+1];
  logic signed [XW-1:0] y_r [STAGES+1];
  logic signed [AW-1:0] a_r [STAGES+1];
  logic                 z_r [STAGES+1];

  logic signed [XW-1:0] xe, ye;
  assign xe = XW'(x_in);
  assign ye = XW'(y_in);

  // pre-rotation: left half-plane folds by pi
  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        a_r[0] <= (y_in >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        a_r[0] <= '0;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_rot
      logic signed [XW-1:0] dx, dy;
      logic signed [AW-1:0] step;
      assign dx   = y_r[i] >>> i;
      assign dy   = x_r[i] >>> i;
      assign step = AW'(q2e_pkg::atan_lut(i));
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i+1] <= z_r[i];
          if (y_r[i] >= 0) begin
            x_r[i+1] <= x_r[i] + dx;
            y_r[i+1] <= y_r[i] - dy;
            a_r[i+1] <= a_r[i] + step;
          end else begin
            x_r[i+1] <= x_r[i] - dx;
            y_r[i+1] <= y_r[i] + dy;
            a_r[i+1] <= a_r[i] - step;
          end
        end
      end
    end
  endgenerate

  assign ang_out  = a_r[STAGES];
  assign zero_out = z_r[STAGES];

endmodule
`default_nettype wire

[src/quaternion_to_euler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler
// attitude quaternion (q2.14) to zyx euler angles roll, yaw (q3.13 rad) and pitch (q2.13 rad)
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (lsb first)
//  in_      | slave     | quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
//  out_     | master    | roll[15:0] pitch[30:16] yaw[46:31] pitch_clamped[47]
//
//  one transaction per cycle in and out while the output is not stalled;
//  the path runs through the front arithmetic, one square root bit per stage,
//  cordic pre-rotation and micro-rotations, then rounding
//  rst_n clears only the stage valid bits
//  when the output register holds an untaken result the whole pipeline
//  freezes; in_tready follows that stall
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // roll, pitch, yaw, pitch_clamped
);

  localparam int PW = $bits(q2e_pkg::ops_t);
  localparam int CL = CORDIC_STAGES + 1;

  logic en;
  logic out_tvalid_r;
  logic [47:0] out_tdata_r;

  // global advance: move when the output slot is free or being drained
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // front end
  logic                   f_vld;
  logic [q2e_pkg::VW-1:0] f_rad;
  q2e_pkg::ops_t          f_ops;

  q2e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_tvalid && in_tready),
    .w       (in_tdata[15:0]),
    .x       (in_tdata[31:16]),
    .y       (in_tdata[47:32]),
    .z       (in_tdata[63:48]),
    .vld_out (f_vld),
    .rad_out (f_rad),
    .ops_out (f_ops)
  );

  // cosine of pitch: sqrt(1 - s*s), roll/yaw operands ride along
  logic                   s_vld;
  logic [q2e_pkg::CW-1:0] s_root;
  logic [PW-1:0]          s_pay;
  q2e_pkg::ops_t          s_ops;

  q2e_isqrt #(.PW(PW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (f_vld),
    .rad_in   (f_rad),
    .pay_in   (f_ops),
    .vld_out  (s_vld),
    .root_out (s_root),
    .pay_out  (s_pay)
  );
  assign s_ops = s_pay;

  // three atan2 units in lockstep
  logic signed [q2e_pkg::AW-1:0] a_roll, a_pitch, a_yaw;
  logic z_roll, z_pitch, z_yaw;

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk (clk), .en (en),
    .y_in (s_ops.roll_y), .x_in (s_ops.roll_x),
    .ang_out (a_roll), .zero_out (z_roll)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk (clk), .en (en),
    .y_in (s_ops.yaw_y), .x_in (s_ops.yaw_x),
    .ang_out (a_yaw), .zero_out (z_yaw)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk (clk), .en (en),
    .y_in (q2e_pkg::OPW'(s_ops.sin_p)),
    .x_in ($signed(q2e_pkg::OPW'(s_root))),
    .ang_out (a_pitch), .zero_out (z_pitch)
  );

  // valid and clamp flag follow the cordic latency
  logic [CL-1:0] cv_r;
  logic [CL-1:0] cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[CL-2:0], s_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= {cc_r[CL-2:0], s_ops.clamped};
    end
  end

  // round half up to q3.13 and saturate
  function automatic logic signed [18:0] to_q13(input logic signed [q2e_pkg::AW-1:0] a,
                                                input logic zero,
                                                input logic signed [18:0] lim);
    logic signed [q2e_pkg::AW:0] t;
    logic signed [18:0] r;
    t = (q2e_pkg::AW+1)'(a) + (q2e_pkg::AW+1)'(65536);
    r = 19'(t >>> 17);
    if (zero) r = '0;
    else if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [18:0] roll_q, pitch_q, yaw_q;
  assign roll_q  = to_q13(a_roll,  z_roll,  q2e_pkg::FULL_LIMIT);
  assign pitch_q = to_q13(a_pitch, z_pitch, q2e_pkg::HALF_LIMIT);
  assign yaw_q   = to_q13(a_yaw,   z_yaw,   q2e_pkg::FULL_LIMIT);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cv_r[CL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {cc_r[CL-1], yaw_q[15:0], pitch_q[14:0], roll_q[15:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
